[hw/rtl/binary_min_heap_queue_defines.svh]
// ----------------------------------------------------------------------------
// binary min-heap queue assertion macros
// shared assertion forms, clocked on clock; one is held off during reset, the other also runs in reset
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// concurrent check, disabled while reset is high
`define BMHQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent check that also runs during reset
`define BMHQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// types and constants shared by the binary min-heap queue modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

   localparam int HEAP_DEPTH    = 1024;
   localparam int VALUE_BITS    = 16;
   localparam int COST_BITS     = 16;
   localparam int ADDR_BITS     = $clog2(HEAP_DEPTH);
   localparam int COUNT_BITS    = $clog2(HEAP_DEPTH + 1);
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = ((VALUE_BITS + COST_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + COST_BITS + COUNT_BITS + 7) / 8) * 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [COST_BITS-1:0]  cost;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_LOAD,
      S_UP_READ,
      S_UP_CMP,
      S_DN_READ,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic ins_start;
      logic reject;
      logic pop_read;
      logic pop_load;
      logic up_read;
      logic up_step;
      logic dn_read;
      logic dn_step;
      logic place;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic req_pop;
      logic full;
      logic empty;
      logic at_root;
      logic up_swap;
      logic leaf;
      logic dn_swap;
   } sts_type;

endpackage

[hw/rtl/bmhq_datapath.sv]
// ----------------------------------------------------------------------------
// bmhq_datapath
// heap store, position and count registers, sift compares, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_datapath
   import bmhq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic                     req_tuser,  // operation
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // item_value, item_cost
   output logic [STATUS_BITS-1:0]   rsp_tuser,  // status
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // out_value, out_cost, entry_count
);

   entry_type mem [HEAP_DEPTH];

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [COUNT_BITS-1:0]    pos_ff, pos_in;
   entry_type                mov_ff, mov_in;
   entry_type                res_ff, res_in;
   status_type               stat_ff, stat_in;
   entry_type                rd_a_ff, rd_b_ff;
   logic [STATUS_BITS-1:0]   rsp_tuser_ff;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff;

   entry_type             req_entry;
   logic [COUNT_BITS:0]   left_pos, right_pos, child_wide;
   logic                  right_ok, take_right;
   entry_type             child;
   logic [COUNT_BITS-1:0] child_pos;
   logic                  rd_en, wr_en;
   logic [ADDR_BITS-1:0]  rd_addr_a, rd_addr_b, wr_addr;
   entry_type             wr_data;

   assign req_entry.value = req_tdata[VALUE_BITS-1:0];
   assign req_entry.cost  = req_tdata[VALUE_BITS +: COST_BITS];

   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign right_ok   = right_pos <= {1'b0, count_ff};
   assign take_right = right_ok && (rd_a_ff.cost >= rd_b_ff.cost);
   assign child      = take_right ? rd_b_ff : rd_a_ff;
   assign child_wide = take_right ? right_pos : left_pos;
   assign child_pos  = child_wide[COUNT_BITS-1:0];

   always_comb begin
      sts.req_pop = (req_tuser == OP_POP);
      sts.full    = (count_ff == COUNT_BITS'(HEAP_DEPTH));
      sts.empty   = (count_ff == '0);
      sts.at_root = (pos_ff == COUNT_BITS'(1));
      sts.up_swap = (rd_a_ff.cost > mov_ff.cost);
      sts.leaf    = (left_pos > {1'b0, count_ff});
      sts.dn_swap = (mov_ff.cost > child.cost);
   end

   // memory port selection
   always_comb begin
      rd_en     = cmd.pop_read | cmd.up_read | cmd.dn_read;
      rd_addr_a = '0;
      rd_addr_b = ADDR_BITS'(count_ff - COUNT_BITS'(1));
      if (cmd.up_read) begin
         rd_addr_a = ADDR_BITS'((pos_ff >> 1) - COUNT_BITS'(1));
      end else if (cmd.dn_read) begin
         rd_addr_a = ADDR_BITS'(left_pos - (COUNT_BITS + 1)'(1));
         rd_addr_b = ADDR_BITS'(left_pos);
      end
      wr_en   = cmd.up_step | cmd.dn_step | cmd.place;
      wr_addr = ADDR_BITS'(pos_ff - COUNT_BITS'(1));
      wr_data = mov_ff;
      if (cmd.up_step) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_step) begin
         wr_data = child;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      mov_in   = mov_ff;
      res_in   = res_ff;
      stat_in  = stat_ff;
      if (cmd.ins_start) begin
         count_in = count_ff + COUNT_BITS'(1);
         pos_in   = count_ff + COUNT_BITS'(1);
         mov_in   = req_entry;
         res_in   = '0;
         stat_in  = ST_OK;
      end
      if (cmd.reject) begin
         res_in  = '0;
         stat_in = sts.req_pop ? ST_EMPTY : ST_FULL;
      end
      if (cmd.pop_load) begin
         count_in = count_ff - COUNT_BITS'(1);
         pos_in   = COUNT_BITS'(1);
         mov_in   = rd_b_ff;
         res_in   = rd_a_ff;
         stat_in  = ST_OK;
      end
      if (cmd.up_step) begin
         pos_in = pos_ff >> 1;
      end
      if (cmd.dn_step) begin
         pos_in = child_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      mov_ff  <= mov_in;
      res_ff  <= res_in;
      stat_ff <= stat_in;
      if (cmd.rsp_load) begin
         rsp_tuser_ff <= stat_ff;
         rsp_tdata_ff <= RSP_DATA_BITS'({count_ff, res_ff.cost, res_ff.value});
      end
   end

   assign rsp_tuser = rsp_tuser_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

[hw/rtl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// sequencer for insert, pop and sift steps, and result handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (sts.req_pop) begin
                  state_in = sts.empty ? S_DONE : S_POP_LOAD;
               end else begin
                  state_in = sts.full ? S_DONE : S_UP_READ;
               end
            end
         end
         S_POP_LOAD: begin
            state_in = S_DN_READ;
         end
         S_UP_READ: begin
            state_in = sts.at_root ? S_DONE : S_UP_CMP;
         end
         S_UP_CMP: begin
            state_in = sts.up_swap ? S_UP_READ : S_DONE;
         end
         S_DN_READ: begin
            state_in = sts.leaf ? S_DONE : S_DN_CMP;
         end
         S_DN_CMP: begin
            state_in = sts.dn_swap ? S_DN_READ : S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (sts.req_pop) begin
                  cmd.reject   = sts.empty;
                  cmd.pop_read = !sts.empty;
               end else begin
                  cmd.reject    = sts.full;
                  cmd.ins_start = !sts.full;
               end
            end
         end
         S_POP_LOAD: begin
            cmd.pop_load = 1'b1;
         end
         S_UP_READ: begin
            cmd.place   = sts.at_root;
            cmd.up_read = !sts.at_root;
         end
         S_UP_CMP: begin
            cmd.up_step = sts.up_swap;
            cmd.place   = !sts.up_swap;
         end
         S_DN_READ: begin
            cmd.place   = sts.leaf;
            cmd.dn_read = !sts.leaf;
         end
         S_DN_CMP: begin
            cmd.dn_step = sts.dn_swap;
            cmd.place   = !sts.dn_swap;
         end
         S_DONE: begin
            cmd.rsp_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[hw/rtl/binary_min_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// min-heap priority queue of (value, cost) entries with insert and pop
// ----------------------------------------------------------------------------
//  channel  direction  ports                          contents
//  req      in         req_tvalid/tready/tdata/tuser  operation, item_value, item_cost
//  rsp      out        rsp_tvalid/tready/tdata/tuser  out_value, out_cost, entry_count, status
//
//  one item at a time, one heap level per read state and compare-write state: an insert
//  sifts up from the new last slot, a pop moves the last entry to the root and sifts it
//  down, and a refused item goes straight to its result
//  a new item is taken while the previous result waits in the output register; a
//  finished item waits in its last state until that register drains
//  synchronous reset empties the heap through the count; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_min_heap_queue
   import bmhq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,  // operation
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // item_value, item_cost
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [STATUS_BITS-1:0]   rsp_tuser,  // status
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // out_value, out_cost, entry_count
);

   cmd_type cmd;
   sts_type sts;

   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bmhq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[hw/rtl/bmhq_checker.sv]
// ----------------------------------------------------------------------------
// bmhq_checker
// port-level checks on the binary min-heap queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_min_heap_queue_defines.svh"

module bmhq_checker
   import bmhq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [STATUS_BITS-1:0]   rsp_tuser,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int CNT_LO = VALUE_BITS + COST_BITS;

   logic                                 req_xfer;
   logic                                 rsp_wait;
   logic                                 rsp_refused;
   logic [CNT_LO-1:0]                    rsp_entry;
   logic [COUNT_BITS-1:0]                rsp_count;
   logic [STATUS_BITS+RSP_DATA_BITS-1:0] rsp_word;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_wait    = rsp_tvalid && !rsp_tready;
   assign rsp_refused = (rsp_tuser == ST_FULL) || (rsp_tuser == ST_EMPTY);
   assign rsp_entry   = rsp_tdata[CNT_LO-1:0];
   assign rsp_count   = rsp_tdata[CNT_LO +: COUNT_BITS];
   assign rsp_word    = {rsp_tuser, rsp_tdata};

   // refused items carry no entry
   `BMHQ_ASSERT(a_refused_zero, rsp_tvalid && rsp_refused |-> rsp_entry == '0, "entry on refusal")

   // the count never passes the depth
   `BMHQ_ASSERT(a_count_range, rsp_tvalid |-> rsp_count <= COUNT_BITS'(HEAP_DEPTH), "count too big")

   // one item at a time: busy right after a transfer in
   `BMHQ_ASSERT_ALWAYS(a_busy_after_req, !reset && req_xfer |=> reset || !req_tready, "taken busy")

   // a stalled result holds
   `BMHQ_ASSERT_ALWAYS(a_rsp_hold, !reset && rsp_wait |=> reset || $stable(rsp_word), "rsp changed")

endmodule

bind binary_min_heap_queue bmhq_checker u_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the min-heap queue against a cycle-free heap predictor: directed
// corner items, a mixed insert/pop run, then a drain past empty
// ----------------------------------------------------------------------------

module tb_top;
   import bmhq_pkg::*;

   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 40;
   localparam int ITEM_TARGET = 550;

   typedef struct {
      op_type                op;
      logic [VALUE_BITS-1:0] value;
      logic [COST_BITS-1:0]  cost;
   } heap_op_t;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic [COST_BITS-1:0]  cost;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
   } heap_result_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic                     req_tuser = 1'b0;  // operation
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;    // item_value, item_cost
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [STATUS_BITS-1:0]   rsp_tuser;         // status
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // out_value, out_cost, entry_count

   heap_op_t     pending_ops[$];
   heap_result_t predicted_results[$];

   entry_type heap_slot [1:HEAP_DEPTH];
   int        heap_fill = 0;
   int        plan_fill = 0;
   int        total_ops = 0;
   int        sent_ops = 0;
   int        errors = 0;
   int        n_checked = 0;
   int        n_full_seen = 0;
   int        n_empty_seen = 0;
   int        max_fill_seen = 0;
   int        req_gap = 0;
   int        req_calm = 0;
   int        rsp_stall = 0;
   int        rsp_calm = 0;
   int        idle_cycles = 0;

   binary_min_heap_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      errors++;
      if (errors <= 100) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int next_gap(inout int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 59) == 0) calm = $urandom_range(20, 80);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COST_BITS-1:0] pick_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return COST_BITS'($urandom_range(0, 15));
      if (r < 36) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return COST_BITS'($urandom);
   endfunction

   task automatic add_op(input op_type op, input logic [VALUE_BITS-1:0] value,
                         input logic [COST_BITS-1:0] cost);
      heap_op_t item;
      item.op    = op;
      item.value = value;
      item.cost  = cost;
      pending_ops.push_back(item);
      total_ops++;
      if (op == OP_INSERT && plan_fill < HEAP_DEPTH) plan_fill++;
      if (op == OP_POP && plan_fill > 0) plan_fill--;
   endtask

   task automatic add_random(input op_type op);
      add_op(op, VALUE_BITS'($urandom), pick_cost());
   endtask

   task automatic swap_slots(input int a, input int b);
      entry_type tmp;
      tmp          = heap_slot[a];
      heap_slot[a] = heap_slot[b];
      heap_slot[b] = tmp;
   endtask

   task automatic predict_heap_op(input heap_op_t item);
      heap_result_t res;
      int           p;
      int           c;
      res.value  = '0;
      res.cost   = '0;
      res.status = ST_OK;
      if (item.op == OP_INSERT) begin
         if (heap_fill >= HEAP_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            heap_fill++;
            p = heap_fill;
            heap_slot[p].value = item.value;
            heap_slot[p].cost  = item.cost;
            while (p > 1 && heap_slot[p / 2].cost > heap_slot[p].cost) begin
               swap_slots(p / 2, p);
               p = p / 2;
            end
         end
      end else if (heap_fill == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.value    = heap_slot[1].value;
         res.cost     = heap_slot[1].cost;
         heap_slot[1] = heap_slot[heap_fill];
         heap_fill--;
         p = 1;
         while (2 * p <= heap_fill) begin
            c = 2 * p;
            if (c + 1 <= heap_fill && heap_slot[c].cost >= heap_slot[c + 1].cost) c = c + 1;
            if (heap_slot[p].cost <= heap_slot[c].cost) break;
            swap_slots(p, c);
            p = c;
         end
      end
      res.count = COUNT_BITS'(heap_fill);
      if (heap_fill > max_fill_seen) max_fill_seen = heap_fill;
      predicted_results.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // request driver
   always @(posedge clock) begin
      heap_op_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            item.op    = op_type'(req_tuser);
            item.value = req_tdata[VALUE_BITS-1:0];
            item.cost  = req_tdata[VALUE_BITS +: COST_BITS];
            predict_heap_op(item);
            sent_ops++;
            req_gap = next_gap(req_calm);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               item = pending_ops.pop_front();
               req_tuser  <= item.op;
               req_tdata  <= {item.cost, item.value};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      heap_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               report("response transfer with nothing outstanding");
            end else begin
               want = predicted_results.pop_front();
               check_field("out_value", 32'(rsp_tdata[VALUE_BITS-1:0]), 32'(want.value));
               check_field("out_cost", 32'(rsp_tdata[VALUE_BITS +: COST_BITS]),
                           32'(want.cost));
               check_field("entry_count",
                           32'(rsp_tdata[VALUE_BITS + COST_BITS +: COUNT_BITS]),
                           32'(want.count));
               check_field("status", 32'(rsp_tuser), 32'(want.status));
               n_checked++;
               if (want.status == ST_FULL) n_full_seen++;
               if (want.status == ST_EMPTY) n_empty_seen++;
            end
            rsp_stall = next_gap(rsp_calm);
         end else if (rsp_tready && rsp_calm == 0 && $urandom_range(0, 19) == 0) begin
            rsp_stall = next_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int seg_left;
      int ins_pct;
      int i;

      // directed corners
      add_op(OP_POP, '1, '1);
      add_op(OP_INSERT, '0, '0);
      add_op(OP_INSERT, '1, '1);
      add_op(OP_INSERT, 16'hAAAA, 16'h5555);
      add_op(OP_INSERT, 16'h5555, 16'hAAAA);
      add_op(OP_INSERT, 16'h0101, 16'd100);
      add_op(OP_INSERT, 16'h0202, 16'd100);
      add_op(OP_INSERT, 16'h0303, 16'd100);
      add_op(OP_INSERT, 16'h0404, 16'd100);
      add_op(OP_INSERT, 16'h0505, 16'd0);
      add_op(OP_INSERT, 16'h0606, '1);
      for (i = 0; i < 11; i++) add_op(OP_POP, VALUE_BITS'($urandom), COST_BITS'($urandom));
      add_op(OP_POP, '0, '0);

      // mixed run in segments that grow, shrink or hover, stopped so that
      // the closing drain lands the whole run near the item target
      seg_left = 0;
      ins_pct  = 50;
      while (total_ops + plan_fill < ITEM_TARGET - 4) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
               0: begin
                  ins_pct = 80;
               end
               1: begin
                  ins_pct = 30;
               end
               default: begin
                  ins_pct = 50;
               end
            endcase
         end
         seg_left--;
         add_random(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP);
      end

      // empty out, pop past empty, then one last insert and pop
      while (plan_fill > 0) add_random(OP_POP);
      for (i = 0; i < 2; i++) add_random(OP_POP);
      add_op(OP_INSERT, '1, '0);
      add_op(OP_POP, '0, '1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (sent_ops < total_ops || predicted_results.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (predicted_results.size() > 0)
         report($sformatf("%0d responses never arrived", predicted_results.size()));

      $display("%0d items sent, %0d responses checked, peak fill %0d of %0d",
               sent_ops, n_checked, max_fill_seen, HEAP_DEPTH);
      $display("%0d overflow refusals, %0d empty pops, %0d mismatches",
               n_full_seen, n_empty_seen, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
